[rtl/u16lx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16lx_pkg
// Shared types and constants for the TLS u16 list extension member check.
// ----------------------------------------------------------------------------
package u16lx_pkg;

  localparam int unsigned PosW     = 17;
  localparam int unsigned CodeW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [PosW-1:0]  PosMax       = {PosW{1'b1}};
  localparam logic [PosW-1:0]  HeaderBytes  = 17'd6;
  localparam logic [PosW-1:0]  TypeLenBytes = 17'd4;
  localparam logic [PosW-1:0]  ListLenBytes = 17'd2;
  localparam logic [PosW-1:0]  PosTypeLo    = 17'd1;
  localparam logic [PosW-1:0]  PosDataLenLo = 17'd3;
  localparam logic [PosW-1:0]  PosListLenLo = 17'd5;

  localparam logic [CodeW-1:0] ExtTypeReset    = 16'd13;
  localparam logic [CodeW-1:0] WantedCodeReset = 16'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXT_TYPE    = 2'd0,
    CFG_WANTED_CODE = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic contains;
    logic well_formed;
  } result_t;

endpackage

[rtl/u16lx_parse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16lx_parse
// Byte-wise framing tracker and list search; yields a result on the last byte.
// ----------------------------------------------------------------------------
module u16lx_parse (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [u16lx_pkg::ByteW-1:0]   data_byte_i,
  input  logic                          last_byte_i,
  input  logic [u16lx_pkg::CodeW-1:0]   ext_type_i,
  input  logic [u16lx_pkg::CodeW-1:0]   wanted_code_i,
  output logic                          res_valid_o,
  output u16lx_pkg::result_t            res_o
);

  logic [u16lx_pkg::PosW-1:0]  pos_q, pos_d;
  logic                        type_ok_q, type_ok_d;
  logic [u16lx_pkg::CodeW-1:0] data_len_q, data_len_d;
  logic [u16lx_pkg::CodeW-1:0] list_len_q, list_len_d;
  logic [u16lx_pkg::ByteW-1:0] high_q, high_d;
  logic                        found_q, found_d;

  logic [u16lx_pkg::CodeW-1:0] word;
  logic [u16lx_pkg::PosW-1:0]  body_off;
  logic [u16lx_pkg::PosW-1:0]  data_need;
  logic [u16lx_pkg::PosW-1:0]  list_plus;
  logic                        wf;

  assign word      = {high_q, data_byte_i};
  assign body_off  = pos_q - u16lx_pkg::HeaderBytes;

  always_comb begin
    pos_d      = pos_q;
    type_ok_d  = type_ok_q;
    data_len_d = data_len_q;
    list_len_d = list_len_q;
    high_d     = high_q;
    found_d    = found_q;
    if (!pos_q[0]) begin
      high_d = data_byte_i;
    end else if (pos_q == u16lx_pkg::PosTypeLo) begin
      type_ok_d = (word == ext_type_i);
    end else if (pos_q == u16lx_pkg::PosDataLenLo) begin
      data_len_d = word;
    end else if (pos_q == u16lx_pkg::PosListLenLo) begin
      list_len_d = word;
    end else if (body_off[u16lx_pkg::PosW-1:1] < {1'b0, list_len_q[u16lx_pkg::CodeW-1:1]}) begin
      if (word == wanted_code_i) begin
        found_d = 1'b1;
      end
    end
    if (pos_q != u16lx_pkg::PosMax) begin
      pos_d = pos_q + 17'd1;
    end
  end

  assign data_need = {1'b0, data_len_d} + u16lx_pkg::TypeLenBytes;
  assign list_plus = {1'b0, list_len_d} + u16lx_pkg::ListLenBytes;
  assign wf = (pos_d >= u16lx_pkg::HeaderBytes) && type_ok_d && (data_need <= pos_d)
              && ({1'b0, data_len_d} == list_plus) && !list_len_d[0];

  assign res_valid_o       = accept_i && last_byte_i;
  assign res_o.well_formed = wf;
  assign res_o.contains    = wf && found_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      type_ok_q  <= 1'b0;
      data_len_q <= '0;
      list_len_q <= '0;
      high_q     <= '0;
      found_q    <= 1'b0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        pos_q      <= '0;
        type_ok_q  <= 1'b0;
        data_len_q <= '0;
        list_len_q <= '0;
        high_q     <= '0;
        found_q    <= 1'b0;
      end else begin
        pos_q      <= pos_d;
        type_ok_q  <= type_ok_d;
        data_len_q <= data_len_d;
        list_len_q <= list_len_d;
        high_q     <= high_d;
        found_q    <= found_d;
      end
    end
  end

endmodule

[rtl/tls_u16_list_ext_member_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_u16_list_ext_member_check
// Streams one TLS extension a byte at a time and reports whether it is well
// framed and lists the wanted 16-bit code.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   in       | in_valid_i/in_stall_o  | data_byte_i, last_byte_i
//   out      | out_valid_o/out_stall_i| contains_o, well_formed_o
//   cfg      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One byte is taken every cycle unless in_stall_o is high; a last byte's
// result goes to the output register, or to the skid stage if that is held.
// A one-entry skid stage behind the output register lets input run on while
// a result waits; input stalls only once both hold results.
// Reset clears the stream state and sets ext_type to 13, wanted_code to 0.
// ----------------------------------------------------------------------------
module tls_u16_list_ext_member_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [u16lx_pkg::ByteW-1:0]     data_byte_i,
  input  logic                            last_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            contains_o,
  output logic                            well_formed_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [u16lx_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [u16lx_pkg::CodeW-1:0]     cfg_data_i
);

  logic [u16lx_pkg::CodeW-1:0] ext_type_q;
  logic [u16lx_pkg::CodeW-1:0] wanted_code_q;

  logic               accept;
  logic               res_valid;
  u16lx_pkg::result_t res;

  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  u16lx_pkg::result_t out_q, out_d;
  u16lx_pkg::result_t skid_q, skid_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_type_q    <= u16lx_pkg::ExtTypeReset;
      wanted_code_q <= u16lx_pkg::WantedCodeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (u16lx_pkg::cfg_idx_e'(cfg_index_i))
        u16lx_pkg::CFG_EXT_TYPE:    ext_type_q    <= cfg_data_i;
        u16lx_pkg::CFG_WANTED_CODE: wanted_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  u16lx_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .ext_type_i    (ext_type_q),
    .wanted_code_i (wanted_code_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // advance output register, park in skid when it is held
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid;
        out_d       = res;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o   = out_valid_q;
  assign contains_o    = out_q.contains;
  assign well_formed_o = out_q.well_formed;

endmodule

[rtl/u16lx_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16lx_checker
// Port-level checks for the TLS u16 list extension member check.
// ----------------------------------------------------------------------------
module u16lx_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_o,
  input  logic last_byte_i,
  input  logic out_valid_o,
  input  logic out_stall_i,
  input  logic contains_o,
  input  logic well_formed_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(contains_o)
    && $stable(well_formed_o))
    else $error("result changed while stalled");

  a_contains_wf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !contains_o || well_formed_o)
    else $error("contains without well_formed");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_byte_i |=> out_valid_o)
    else $error("last item gave no result");

endmodule

bind tls_u16_list_ext_member_check u16lx_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .last_byte_i   (last_byte_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .contains_o    (contains_o),
  .well_formed_o (well_formed_o)
);

[dv/tls_u16_list_ext_member_check_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_u16_list_ext_member_check_test
// Self-checking bench for the u16 list extension member check. Feeds a short
// table of hand-built extensions (short, mistyped, trailing byte, odd list,
// overlong declared length), then random extensions, well framed or not,
// under three register settings and three idling patterns. Every verdict is
// compared with a table value or a cycle-free predictor of the byte parser.
// ----------------------------------------------------------------------------
module tls_u16_list_ext_member_check_test;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned PhaseItems  = 430;
  localparam int unsigned DirRows     = 31;
  localparam logic [u16lx_pkg::CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  localparam u16lx_pkg::result_t Rejected = '{contains: 1'b0, well_formed: 1'b0};

  typedef struct packed {
    logic [u16lx_pkg::ByteW-1:0] data;
    logic                        last;
  } ext_byte_t;

  typedef struct packed {
    logic [u16lx_pkg::ByteW-1:0] data;
    logic                        last;
    logic [u16lx_pkg::PosW-1:0]  reps;
    logic                        typed;
    u16lx_pkg::result_t          want;
  } dir_vec_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [u16lx_pkg::ByteW-1:0]   data_byte_i;
  logic                          last_byte_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          contains_o;
  logic                          well_formed_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [u16lx_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [u16lx_pkg::CodeW-1:0]   cfg_data_i;

  // parser state as the block should hold it
  logic [u16lx_pkg::CodeW-1:0] ext_type_m;
  logic [u16lx_pkg::CodeW-1:0] wanted_m;
  logic [u16lx_pkg::PosW-1:0]  pos_m;
  logic                        type_ok_m;
  logic [u16lx_pkg::CodeW-1:0] data_len_m;
  logic [u16lx_pkg::CodeW-1:0] list_len_m;
  logic [u16lx_pkg::ByteW-1:0] hi_byte_m;
  logic                        found_m;

  u16lx_pkg::result_t verdict_q[$];
  u16lx_pkg::result_t head_verdict;
  ext_byte_t          stream_q[$];
  ext_byte_t          cur_byte;
  int unsigned        snd_idle;
  int unsigned        rcv_idle;
  int unsigned        cycle_cnt = 0;
  int unsigned        bytes_sent = 0;
  int unsigned        verdicts_seen = 0;
  int unsigned        wf_seen = 0;
  int unsigned        hits_seen = 0;
  int unsigned        fail_cnt = 0;
  int unsigned        sent;

  dir_vec_t dir_tab [DirRows] = '{
    // short buffer
    '{8'h00, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h0D, 1'b1, 17'd1, 1'b1, Rejected},
    // all-ones type, never matches reset type
    '{8'hFF, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'hFF, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h00, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h02, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h00, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h00, 1'b1, 17'd1, 1'b1, Rejected},
    // one entry equal to the wanted code, one byte past the list
    '{8'h00, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h0D, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h00, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h04, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h00, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h02, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h00, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h00, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'hAA, 1'b1, 17'd1, 1'b0, Rejected},
    // odd list length
    '{8'h00, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h0D, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h00, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h03, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h00, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h01, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h00, 1'b1, 17'd1, 1'b1, Rejected},
    // near-maximal declared lengths over a short buffer
    '{8'h00, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'h0D, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'hFF, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'hFE, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'hFF, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'hFC, 1'b0, 17'd1, 1'b0, Rejected},
    '{8'hAB, 1'b0, 17'd8, 1'b0, Rejected}
  };

  tls_u16_list_ext_member_check i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .contains_o    (contains_o),
    .well_formed_o (well_formed_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rcv_idle);
  end

  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL tls_u16_list_ext_member_check");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict: contains %0b, well_formed %0b", contains_o, well_formed_o);
        fail_cnt++;
      end else begin
        head_verdict = verdict_q.pop_front();
        if (contains_o !== head_verdict.contains) begin
          $error("contains: expected %0b, actual %0b", head_verdict.contains, contains_o);
          fail_cnt++;
        end
        if (well_formed_o !== head_verdict.well_formed) begin
          $error("well_formed: expected %0b, actual %0b", head_verdict.well_formed,
                 well_formed_o);
          fail_cnt++;
        end
        verdicts_seen++;
        if (head_verdict.well_formed) wf_seen++;
        if (head_verdict.contains) hits_seen++;
      end
    end
  end

  task automatic clear_ext_state();
    pos_m      = '0;
    type_ok_m  = 1'b0;
    data_len_m = '0;
    list_len_m = '0;
    hi_byte_m  = '0;
    found_m    = 1'b0;
  endtask

  task automatic track_ext_byte(input logic [u16lx_pkg::ByteW-1:0] b, input logic l,
                                output bit done, output u16lx_pkg::result_t v);
    logic [u16lx_pkg::CodeW-1:0] word;
    int unsigned                 n;
    bit                          ok;
    word = {hi_byte_m, b};
    done = 1'b0;
    v    = Rejected;
    if (!pos_m[0]) begin
      hi_byte_m = b;
    end else if (pos_m == u16lx_pkg::PosTypeLo) begin
      type_ok_m = (word == ext_type_m);
    end else if (pos_m == u16lx_pkg::PosDataLenLo) begin
      data_len_m = word;
    end else if (pos_m == u16lx_pkg::PosListLenLo) begin
      list_len_m = word;
    end else if (((pos_m - u16lx_pkg::HeaderBytes) >> 1) < (list_len_m >> 1)) begin
      if (word == wanted_m) found_m = 1'b1;
    end
    if (pos_m != u16lx_pkg::PosMax) pos_m = pos_m + 1'b1;
    if (l) begin
      n  = pos_m;
      ok = (n >= u16lx_pkg::HeaderBytes) && type_ok_m
           && (32'(data_len_m) + u16lx_pkg::TypeLenBytes <= n)
           && (32'(data_len_m) == 32'(list_len_m) + u16lx_pkg::ListLenBytes)
           && !list_len_m[0];
      v.contains    = ok && found_m;
      v.well_formed = ok;
      done          = 1'b1;
      clear_ext_state();
    end
  endtask

  // enter and leave at a falling edge
  task automatic send_byte(input logic [u16lx_pkg::ByteW-1:0] b, input logic l,
                           input logic typed, input u16lx_pkg::result_t typed_v);
    bit                 done;
    u16lx_pkg::result_t v;
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    bytes_sent++;
    track_ext_byte(b, l, done, v);
    if (done) verdict_q.push_back(typed ? typed_v : v);
  endtask

  task automatic write_reg(input logic [u16lx_pkg::CfgIdxW-1:0] idx,
                           input logic [u16lx_pkg::CodeW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      u16lx_pkg::CFG_EXT_TYPE:    ext_type_m = val;
      u16lx_pkg::CFG_WANTED_CODE: wanted_m   = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic queue_extension();
    logic [u16lx_pkg::ByteW-1:0] seq[$];
    logic [u16lx_pkg::CodeW-1:0] typ;
    logic [u16lx_pkg::CodeW-1:0] dlen;
    logic [u16lx_pkg::CodeW-1:0] llen;
    logic [u16lx_pkg::CodeW-1:0] word;
    int                          nbody;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 10)) seq.push_back(8'($urandom));
    end else begin
      typ  = ($urandom_range(99) < 80) ? ext_type_m : 16'($urandom);
      llen = 16'(2 * $urandom_range(0, 8));
      case ($urandom_range(9))
        0: llen = llen | 16'd1;
        1: llen = 16'($urandom);
        default: ;
      endcase
      dlen = llen + 16'd2;
      if ($urandom_range(9) == 0) dlen = 16'($urandom_range(0, 24));
      seq.push_back(typ[15:8]);
      seq.push_back(typ[7:0]);
      seq.push_back(dlen[15:8]);
      seq.push_back(dlen[7:0]);
      seq.push_back(llen[15:8]);
      seq.push_back(llen[7:0]);
      nbody = (llen > 16'd20) ? $urandom_range(0, 20) : int'(llen);
      for (int k = 0; k < nbody; k += 2) begin
        word = ($urandom_range(99) < 30) ? wanted_m : 16'($urandom);
        seq.push_back(word[15:8]);
        if (k + 1 < nbody) seq.push_back(word[7:0]);
      end
      repeat (($urandom_range(99) < 25) ? $urandom_range(1, 3) : 0)
        seq.push_back(8'($urandom));
      if ($urandom_range(99) < 10)
        repeat ($urandom_range(1, seq.size() - 1)) void'(seq.pop_back());
    end
    for (int k = 0; k < seq.size(); k++)
      stream_q.push_back('{data: seq[k], last: (k == seq.size() - 1)});
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    data_byte_i <= '0;
    last_byte_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= u16lx_pkg::CFG_EXT_TYPE;
    cfg_data_i  <= '0;
    snd_idle    = 27;
    rcv_idle    = 78;
    ext_type_m  = u16lx_pkg::ExtTypeReset;
    wanted_m    = u16lx_pkg::WantedCodeReset;
    clear_ext_state();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirRows; i++)
      for (int k = 0; k < dir_tab[i].reps; k++)
        send_byte(dir_tab[i].data, dir_tab[i].last && (k == dir_tab[i].reps - 1),
                  dir_tab[i].typed, dir_tab[i].want);
    // close the overlong extension
    send_byte(8'h00, 1'b1, 1'b0, Rejected);

    for (int phase = 0; phase < 3; phase++) begin
      in_valid_i <= 1'b0;
      while (verdict_q.size() != 0) @(negedge clk_i);
      repeat (4) @(negedge clk_i);
      case (phase)
        0: begin
          write_reg(u16lx_pkg::CFG_EXT_TYPE, 16'd10);
          write_reg(u16lx_pkg::CFG_WANTED_CODE, 16'($urandom));
          snd_idle = 27;
          rcv_idle = 78;
        end
        1: begin
          write_reg(u16lx_pkg::CFG_EXT_TYPE, 16'hFFFF);
          write_reg(u16lx_pkg::CFG_WANTED_CODE, 16'hFFFF);
          write_reg(CfgIdxSpare, 16'($urandom));
          snd_idle = 78;
          rcv_idle = 27;
        end
        default: begin
          write_reg(u16lx_pkg::CFG_EXT_TYPE, 16'h0000);
          write_reg(u16lx_pkg::CFG_WANTED_CODE, 16'h0000);
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      cfg_valid_i <= 1'b0;
      // leftover bytes of a split extension run on under the new setting
      sent = 0;
      while (sent < PhaseItems) begin
        if (stream_q.size() == 0) queue_extension();
        cur_byte = stream_q.pop_front();
        send_byte(cur_byte.data, cur_byte.last, 1'b0, Rejected);
        sent++;
      end
    end
    while (stream_q.size() != 0) begin
      cur_byte = stream_q.pop_front();
      send_byte(cur_byte.data, cur_byte.last, 1'b0, Rejected);
    end
    in_valid_i <= 1'b0;

    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("Checked %0d verdicts over %0d bytes: %0d well framed, %0d holding the code.",
             verdicts_seen, bytes_sent, wf_seen, hits_seen);
    $display("Ran short, mistyped, odd and overlong buffers under three register settings.");
    if (fail_cnt == 0) begin
      $display("PASS tls_u16_list_ext_member_check");
    end else begin
      $display("FAIL tls_u16_list_ext_member_check");
    end
    $finish;
  end

endmodule
